### hdl/flash_wear_leveled_channel_store_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wear-leveled channel store checker.
// Each macro expects signals named clk and arst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef FLASH_WEAR_LEVELED_CHANNEL_STORE_ASSERT_SVH
`define FLASH_WEAR_LEVELED_CHANNEL_STORE_ASSERT_SVH

// Same-cycle implication.
`define FWLCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define FWLCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/fwlcs_pkg.sv
// ---------------------------------------------------------------------------
// fwlcs_pkg
// Types, constants and codes shared by the channel store modules.
// ---------------------------------------------------------------------------
package fwlcs_pkg;

	localparam int CHANNELS = 16;
	localparam int ROWS     = 128;
	localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FILL_W   = $clog2(ROWS + 1);
	localparam int ADDR_W   = $clog2(CHANNELS * ROWS);
	localparam logic [15:0] SLOT_ERASED = 16'hFFFF;

	// Result status codes.
	typedef enum logic [2:0] {
		RS_WRITTEN   = 3'd0,
		RS_UNCHANGED = 3'd1,
		RS_ERASED    = 3'd2,
		RS_LOADED    = 3'd3,
		RS_BAD_CH    = 3'd4,
		RS_BAD_VAL   = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_CHK,
		S_REP_RD,
		S_REP_WR,
		S_RES
	} state_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  channel;
		logic [15:0] frequency;
	} req_t;

	typedef struct packed {
		logic [15:0] value;
		status_t     status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    use_idx;
		logic    mem_rd;
		logic    wr_store;
		logic    rep_wr;
		logic    idx_clr;
		logic    idx_inc;
		logic    set_res;
		status_t res_code;
		logic    res_push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_ch;
		logic is_load;
		logic bad_val;
		logic fill_zero;
		logic full;
		logic same;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage

### hdl/fwlcs_if.sv
// ---------------------------------------------------------------------------
// fwlcs_req_if / fwlcs_rsp_if
// Valid/ready channels for store and load requests and their results.
// ---------------------------------------------------------------------------
interface fwlcs_req_if;
	import fwlcs_pkg::*;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  channel;
	logic [15:0] frequency;
	modport source (output valid, action, channel, frequency, input ready);
	modport sink (input valid, action, channel, frequency, output ready);
endinterface

interface fwlcs_rsp_if;
	import fwlcs_pkg::*;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [2:0]  status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

### hdl/fwlcs_ctrl.sv
// ---------------------------------------------------------------------------
// fwlcs_ctrl
// Sequencer for lookup, store, repack and result delivery.
// ---------------------------------------------------------------------------
module fwlcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fwlcs_pkg::sts_t sts,
	output fwlcs_pkg::cmd_t cmd
);
	import fwlcs_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOOK;
			end
			S_LOOK: state_d = S_CHK;
			S_CHK: begin
				if (!sts.bad_ch && !sts.is_load && !sts.bad_val && sts.full) begin
					state_d = S_REP_RD;
				end else begin
					state_d = S_RES;
				end
			end
			S_REP_RD: state_d = S_REP_WR;
			S_REP_WR: begin
				state_d = sts.idx_last ? S_RES : S_REP_RD;
			end
			S_RES: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		cmd.res_code = RS_WRITTEN;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			S_LOOK: begin
				cmd.mem_rd = !sts.bad_ch;
			end
			S_CHK: begin
				cmd.set_res = 1'b1;
				if (sts.bad_ch) begin
					cmd.res_code = RS_BAD_CH;
				end else if (sts.is_load) begin
					cmd.res_code = RS_LOADED;
				end else if (sts.bad_val) begin
					cmd.res_code = RS_BAD_VAL;
				end else if (sts.full) begin
					cmd.set_res = 1'b0;
					cmd.idx_clr = 1'b1;
				end else if (!sts.fill_zero && sts.same) begin
					cmd.res_code = RS_UNCHANGED;
				end else begin
					cmd.res_code = RS_WRITTEN;
					cmd.wr_store = 1'b1;
				end
			end
			S_REP_RD: begin
				cmd.use_idx = 1'b1;
				cmd.mem_rd = 1'b1;
			end
			S_REP_WR: begin
				cmd.use_idx = 1'b1;
				cmd.rep_wr = 1'b1;
				cmd.idx_inc = !sts.idx_last;
				cmd.set_res = sts.idx_last;
				cmd.res_code = RS_ERASED;
			end
			S_RES: begin
				cmd.res_push = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/fwlcs_dp.sv
// ---------------------------------------------------------------------------
// fwlcs_dp
// Page memory, per-channel fill counts, repack index and result registers.
// ---------------------------------------------------------------------------
module fwlcs_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  fwlcs_pkg::req_t in_data,
	input  fwlcs_pkg::cmd_t cmd,
	output fwlcs_pkg::sts_t sts,
	output logic            out_valid,
	input  logic            out_ready,
	output fwlcs_pkg::rsp_t out_data
);
	import fwlcs_pkg::*;

	logic [15:0]     mem [CHANNELS * ROWS];
	logic [FILL_W-1:0] fill_q [CHANNELS];

	req_t            req_q;
	logic [CW-1:0]   idx_q;
	logic [15:0]     rd_q;
	logic [15:0]     res_value_q;
	status_t         res_status_q;
	logic            out_valid_q;
	rsp_t            out_data_q;

	logic            bad_ch;
	logic [CW-1:0]   col;
	logic [CW-1:0]   sel;
	logic [FILL_W-1:0] fill_sel;
	logic            fill_zero;
	logic [FILL_W-1:0] row_rd;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [15:0]     wr_data;
	logic [15:0]     newest;
	logic            mem_we;
	logic [15:0]     res_value;

	// Request decode and fill count selection.
	assign bad_ch    = (req_q.channel == 8'd0) || (req_q.channel > 8'(CHANNELS));
	assign col       = CW'(req_q.channel - 8'd1);
	assign sel       = cmd.use_idx ? idx_q : col;
	assign fill_sel  = fill_q[sel];
	assign fill_zero = (fill_sel == '0);
	assign row_rd    = fill_sel - FILL_W'(1);
	assign newest    = fill_zero ? 16'd0 : rd_q;

	// Slot addresses: newest slot of the selected column, and its first free slot.
	assign rd_addr = ADDR_W'(32'(row_rd) * CHANNELS + 32'(sel));
	assign mem_we  = cmd.wr_store || cmd.rep_wr;
	assign wr_addr = cmd.rep_wr ? ADDR_W'(idx_q)
		: ADDR_W'(32'(fill_sel) * CHANNELS + 32'(col));
	assign wr_data = (cmd.rep_wr && (idx_q != col)) ? newest : req_q.frequency;

	// Page memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.mem_rd && !fill_zero) begin
			rd_q <= mem[rd_addr];
		end
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
	end

	// Fill counts and repack index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) fill_q[i] <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.wr_store) begin
				fill_q[col] <= fill_sel + FILL_W'(1);
			end
			if (cmd.rep_wr) begin
				fill_q[idx_q] <= FILL_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Result value for the chosen status.
	always_comb begin
		case (cmd.res_code)
			RS_LOADED:    res_value = newest;
			RS_WRITTEN,
			RS_UNCHANGED,
			RS_ERASED:    res_value = req_q.frequency;
			default:      res_value = 16'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_value_q  <= res_value;
			res_status_q <= cmd.res_code;
		end
		if (cmd.res_push) begin
			out_data_q.value  <= res_value_q;
			out_data_q.status <= res_status_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.bad_ch    = bad_ch;
	assign sts.is_load   = req_q.action;
	assign sts.bad_val   = (req_q.frequency == SLOT_ERASED);
	assign sts.fill_zero = fill_zero;
	assign sts.full      = (fill_sel == FILL_W'(ROWS));
	assign sts.same      = (rd_q == req_q.frequency);
	assign sts.idx_last  = (idx_q == CW'(CHANNELS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

### hdl/flash_wear_leveled_channel_store.sv
// Requests are taken one at a time: a new one is accepted only after the result
// of the last has moved into the output register, which waits until any held
// result is taken by ready. A store into a full column repacks the page.
// Reset: arst_n clears all fill counts, which erases the page at once.
// ---------------------------------------------------------------------------
// flash_wear_leveled_channel_store
// Wear-leveled per-channel value store on one erasable page.
// ---------------------------------------------------------------------------
module flash_wear_leveled_channel_store (
	input  logic        clk,
	input  logic        arst_n,
	fwlcs_req_if.sink   req,
	fwlcs_rsp_if.source rsp
);
	import fwlcs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	req_t in_data;
	rsp_t out_data;

	assign in_data.action    = req.action;
	assign in_data.channel   = req.channel;
	assign in_data.frequency = req.frequency;

	fwlcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fwlcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign rsp.value  = out_data.value;
	assign rsp.status = out_data.status;

endmodule

### hdl/fwlcs_checker.sv
// ---------------------------------------------------------------------------
// fwlcs_checker
// Port-level checks on the channel store, bound to the top level.
// ---------------------------------------------------------------------------
`include "flash_wear_leveled_channel_store_assert.svh"

module fwlcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] value,
	input logic [2:0]  status
);
	import fwlcs_pkg::*;

	// Only one request is in flight.
	`FWLCS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// Rejected requests always report a zero value.
	`FWLCS_ASSERT_NOW(a_bad_zero, out_valid && (status == RS_BAD_CH || status == RS_BAD_VAL), value == 16'd0)
	// A written value is never the erased code.
	`FWLCS_ASSERT_NOW(a_no_erased, out_valid && (status == RS_WRITTEN || status == RS_ERASED), value != SLOT_ERASED)
	// A stalled result holds.
	`FWLCS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(status))

endmodule

bind flash_wear_leveled_channel_store fwlcs_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.value     (rsp.value),
	.status    (rsp.status)
);

### tb/sv/flash_wear_leveled_channel_store_tb.sv
// ---------------------------------------------------------------------------
// flash_wear_leveled_channel_store_tb
// Self-checking testbench for the wear-leveled channel store. Requests go in
// from a queue through a clocked driver. A clocked monitor predicts each
// result from a shadow of the fill level and newest value of every column.
// It then compares each result, in order, with the prediction. The stimulus
// covers the edge cases, then runs store bursts that fill columns to force
// repacks, with loads and random noise mixed in.
// ---------------------------------------------------------------------------
module flash_wear_leveled_channel_store_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fwlcs_pkg::*;

	localparam int ITEMS_TARGET = 1050;
	localparam int SETTLE_CYCLES = 2 * CHANNELS + 3 + 20;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		req_t req;
		bit   drain;
	} pending_req_t;

	logic clk;
	logic arst_n;

	fwlcs_req_if req ();
	fwlcs_rsp_if rsp ();

	flash_wear_leveled_channel_store uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Shadow of the page: how many rows each column has used and its newest value.
	int unsigned col_fill[CHANNELS];
	logic [15:0] col_newest[CHANNELS];

	pending_req_t pending_reqs[$];
	rsp_t         expected_rsps[$];
	int           sent_count;
	int           mismatches;
	int           stall_cycles;
	int           n_stores, n_loads, n_errors, n_repacks;
	int           send_idle_pct, recv_idle_pct;

	// Clock generation.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Works out the result of one request and updates the shadow page.
	function automatic rsp_t store_predict(req_t r);
		rsp_t res;
		int   col;
		res.value = 16'd0;
		if (r.channel == 8'd0 || r.channel > CHANNELS) begin
			res.status = RS_BAD_CH;
			n_errors++;
			return res;
		end
		col = r.channel - 1;
		if (r.action) begin
			res.value = (col_fill[col] == 0) ? 16'd0 : col_newest[col];
			res.status = RS_LOADED;
			n_loads++;
			return res;
		end
		if (r.frequency == SLOT_ERASED) begin
			res.status = RS_BAD_VAL;
			n_errors++;
			return res;
		end
		n_stores++;
		res.value = r.frequency;
		if (col_fill[col] == ROWS) begin
			// Full column: every channel lands in row 0, unused ones as zero.
			for (int i = 0; i < CHANNELS; i++) begin
				if (col_fill[i] == 0)
					col_newest[i] = 16'd0;
				col_fill[i] = 1;
			end
			col_newest[col] = r.frequency;
			res.status = RS_ERASED;
			n_repacks++;
		end else if (col_fill[col] > 0 && col_newest[col] == r.frequency) begin
			res.status = RS_UNCHANGED;
		end else begin
			col_newest[col] = r.frequency;
			col_fill[col]++;
			res.status = RS_WRITTEN;
		end
		return res;
	endfunction

	task automatic queue_req(bit action, logic [7:0] channel, logic [15:0] frequency,
			bit drain = 1'b0);
		pending_req_t p;
		p.req.action = action;
		p.req.channel = channel;
		p.req.frequency = frequency;
		p.drain = drain;
		pending_reqs.push_back(p);
	endtask

	// Request driver: changes the request inputs and rsp.ready on the falling edge.
	bit req_taken;
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (!req.valid || req_taken) begin
			if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain && expected_rsps.size() > 0) &&
					$urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.action <= pending_reqs[0].req.action;
				req.channel <= pending_reqs[0].req.channel;
				req.frequency <= pending_reqs[0].req.frequency;
				void'(pending_reqs.pop_front());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted request and checks each result.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		req_t r;
		req_taken <= 1'b0;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				r.action = req.action;
				r.channel = req.channel;
				r.frequency = req.frequency;
				expected_rsps.push_back(store_predict(r));
				req_taken <= 1'b1;
				sent_count++;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result value=%h status=%0d",
							rsp.value, rsp.status);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.value !== exp_rsp.value || rsp.status !== exp_rsp.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
								exp_rsp.value, exp_rsp.status, rsp.value, rsp.status);
					end
				end
			end
			// Watchdog on cycles with no handshake at all.
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog timeout");
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int ch, len;
		logic [15:0] base;
		req.valid = 1'b0;
		req.action = 1'b0;
		req.channel = 8'd0;
		req.frequency = 16'd0;
		rsp.ready = 1'b0;
		req_taken = 1'b0;
		sent_count = 0;
		mismatches = 0;
		stall_cycles = 0;
		n_stores = 0;
		n_loads = 0;
		n_errors = 0;
		n_repacks = 0;
		send_idle_pct = 25;
		recv_idle_pct = 53;
		for (int i = 0; i < CHANNELS; i++) begin
			col_fill[i] = 0;
			col_newest[i] = 16'd0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: bad channels, empty loads, bad value, repeats, extremes.
		queue_req(1'b0, 8'd0, 16'h1234);
		queue_req(1'b1, 8'd0, 16'h0000);
		queue_req(1'b0, 8'(CHANNELS + 1), 16'h0001);
		queue_req(1'b1, 8'd255, 16'hFFFF);
		queue_req(1'b1, 8'd1, 16'h0000);
		queue_req(1'b1, 8'(CHANNELS), 16'h5555);
		queue_req(1'b0, 8'd1, 16'hFFFF);
		queue_req(1'b0, 8'd1, 16'h0000);
		queue_req(1'b0, 8'd1, 16'h0000);
		queue_req(1'b1, 8'd1, 16'h0000);
		queue_req(1'b0, 8'(CHANNELS), 16'hFFFE);
		queue_req(1'b0, 8'(CHANNELS), 16'hFFFE);
		queue_req(1'b0, 8'(CHANNELS), 16'hAAAA);
		queue_req(1'b1, 8'(CHANNELS), 16'h0000);
		queue_req(1'b0, 8'd2, 16'h8000);
		queue_req(1'b1, 8'd2, 16'h0000);
		queue_req(1'b0, 8'd255, 16'hFFFF);

		// Random part: store bursts that can fill a column, loads and noise.
		while (pending_reqs.size() + 17 < ITEMS_TARGET) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					ch = $urandom_range(1, CHANNELS);
					len = ($urandom_range(3) == 0) ? ROWS + $urandom_range(4)
						: $urandom_range(1, 20);
					base = 16'($urandom_range(16'hFF00));
					for (int k = 0; k < len; k++) begin
						// Sometimes repeat the value to hit the unchanged case.
						queue_req(1'b0, 8'(ch),
							($urandom_range(15) == 0) ? base : 16'(base + k + 1),
							(pending_reqs.size() == ITEMS_TARGET / 3 ||
							 pending_reqs.size() == 2 * ITEMS_TARGET / 3));
						if ($urandom_range(15) == 0)
							queue_req(1'b1, 8'(ch), 16'($urandom));
					end
				end
				4, 5, 6: begin
					queue_req(1'b1, 8'($urandom_range(1, CHANNELS)), 16'($urandom));
				end
				default: begin
					queue_req(1'($urandom_range(1)), 8'($urandom_range(255)),
						($urandom_range(7) == 0) ? SLOT_ERASED : 16'($urandom));
				end
			endcase
		end
		queue_req(1'b0, 8'd3, 16'h0101, 1'b1);

		// Idling phases follow progress through the item count.
		wait (sent_count >= ITEMS_TARGET / 3);
		send_idle_pct = 53;
		recv_idle_pct = 25;
		wait (sent_count >= 2 * ITEMS_TARGET / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;

		wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d requests: %0d stores, %0d loads, %0d rejects.",
			sent_count, n_stores, n_loads, n_errors);
		$display("Full columns forced %0d page repacks; %0d mismatches seen.",
			n_repacks, mismatches);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
